// ===== sv/cbq_pkg.sv =====
// ----------------------------------------------------------------------------
// cbq_pkg: shared definitions for the cascaded biquad filter
// Widths, fixed-point constants, command codes and the cell link types.
// ----------------------------------------------------------------------------
package cbq_pkg;

  localparam int MAX_STAGES  = 16;
  localparam int SAMPLE_BITS = 24;

  localparam int HIST_BITS  = 32;
  localparam int COEF_BITS  = 32;
  localparam int COEF_SLOTS = 5;
  localparam int SLOT_BITS  = 3;
  localparam int CIDX_BITS  = 7;
  localparam int FUNC_BITS  = 2;
  localparam int SC_BITS    = 5;
  localparam int GAIN_BITS  = 31;
  localparam int CFG_BITS   = 31;
  localparam int CFG_IDX_BITS = 1;

  // Q3.28 coefficients: the five products sum into 67 bits with room to spare
  localparam int FRAC_BITS = 28;
  localparam int PROD_BITS = 2 * HIST_BITS;
  localparam int ACC_BITS  = PROD_BITS + 3;
  localparam int YW_BITS   = ACC_BITS - FRAC_BITS;

  // Q1.30 output gain
  localparam int GAIN_FRAC = 30;
  localparam int GW_BITS   = PROD_BITS - GAIN_FRAC;

  localparam logic signed [ACC_BITS-1:0] STAGE_ROUND =
    ACC_BITS'(1) << (FRAC_BITS - 1);
  localparam logic signed [PROD_BITS-1:0] GAIN_ROUND =
    PROD_BITS'(1) << (GAIN_FRAC - 1);
  localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(1) << GAIN_FRAC;

  localparam logic [FUNC_BITS-1:0] FUNC_FILTER = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_COEF   = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] REG_STAGE_COUNT = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_OUTPUT_GAIN = 1'd1;

  localparam logic [SLOT_BITS-1:0] SLOT_B0 = 3'd0;
  localparam logic [SLOT_BITS-1:0] SLOT_B1 = 3'd1;
  localparam logic [SLOT_BITS-1:0] SLOT_B2 = 3'd2;
  localparam logic [SLOT_BITS-1:0] SLOT_A1 = 3'd3;
  localparam logic [SLOT_BITS-1:0] SLOT_A2 = 3'd4;
  localparam logic [SLOT_BITS-1:0] SLOT_LAST = 3'd5;

  // Value handed from one section to the next
  typedef struct packed {
    logic                        valid;
    logic signed [HIST_BITS-1:0] value;
    logic                        clip;
  } link_t;

  // Per-section control from the top level
  typedef struct packed {
    logic                        clear;
    logic                        coef_we;
    logic [SLOT_BITS-1:0]        slot;
    logic signed [COEF_BITS-1:0] coef_value;
    logic                        enable;
  } ctrl_t;

endpackage

// ===== sv/cbq_in_if.sv =====
// ----------------------------------------------------------------------------
// cbq_in_if: input channel of the biquad cascade
// Valid/ready channel carrying one command beat.
// ----------------------------------------------------------------------------
interface cbq_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [cbq_pkg::FUNC_BITS-1:0]         func;
  logic signed [cbq_pkg::SAMPLE_BITS-1:0] sample_in;
  logic [cbq_pkg::CIDX_BITS-1:0]         coef_index;
  logic signed [cbq_pkg::COEF_BITS-1:0]  coef_value;

  modport source (output valid, func, sample_in, coef_index, coef_value, input ready);
  modport sink (input valid, func, sample_in, coef_index, coef_value, output ready);
endinterface

// ===== sv/cbq_out_if.sv =====
// ----------------------------------------------------------------------------
// cbq_out_if: output channel of the biquad cascade
// Valid/ready channel carrying one filtered sample beat.
// ----------------------------------------------------------------------------
interface cbq_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [cbq_pkg::SAMPLE_BITS-1:0] sample_out;
  logic                                  saturated;

  modport source (output valid, sample_out, saturated, input ready);
  modport sink (input valid, sample_out, saturated, output ready);
endinterface

// ===== sv/cbq_cell.sv =====
// ----------------------------------------------------------------------------
// cbq_cell: one direct-form-1 second-order section
// Holds its own five coefficients and history; runs five products through
// one multiplier, then rounds, saturates and hands the value on.
// ----------------------------------------------------------------------------
module cbq_cell (
  input  logic           clk,
  input  logic           rst,
  input  cbq_pkg::ctrl_t ctrl,
  input  cbq_pkg::link_t prev,
  output cbq_pkg::link_t next
);

  logic signed [cbq_pkg::COEF_BITS-1:0] coef [cbq_pkg::COEF_SLOTS];
  logic signed [cbq_pkg::HIST_BITS-1:0] x0, x1, x2, y1, y2;
  logic                                 busy;
  logic [cbq_pkg::SLOT_BITS-1:0]        phase;
  logic signed [cbq_pkg::PROD_BITS-1:0] prod;
  logic                                 prod_neg;
  logic signed [cbq_pkg::ACC_BITS-1:0]  acc;
  logic                                 clip_l;
  logic                                 out_valid;
  logic signed [cbq_pkg::HIST_BITS-1:0] out_value;
  logic                                 out_clip;

  logic signed [cbq_pkg::COEF_BITS-1:0] coef_sel;
  logic signed [cbq_pkg::HIST_BITS-1:0] operand;
  logic signed [cbq_pkg::ACC_BITS-1:0]  term;
  logic signed [cbq_pkg::ACC_BITS-1:0]  acc_sum;
  logic signed [cbq_pkg::YW_BITS-1:0]   y_wide;
  logic signed [cbq_pkg::HIST_BITS-1:0] y_sat;
  logic                                 y_clip;

  always_comb begin
    case (phase)
      cbq_pkg::SLOT_B0: begin
        coef_sel = coef[0];
        operand  = x0;
      end
      cbq_pkg::SLOT_B1: begin
        coef_sel = coef[1];
        operand  = x1;
      end
      cbq_pkg::SLOT_B2: begin
        coef_sel = coef[2];
        operand  = x2;
      end
      cbq_pkg::SLOT_A1: begin
        coef_sel = coef[3];
        operand  = y1;
      end
      default: begin
        coef_sel = coef[4];
        operand  = y2;
      end
    endcase
  end

  // feedback terms enter with a minus sign
  assign term    = prod_neg ? -cbq_pkg::ACC_BITS'(prod) : cbq_pkg::ACC_BITS'(prod);
  assign acc_sum = acc + term;
  assign y_wide  = acc_sum[cbq_pkg::ACC_BITS-1:cbq_pkg::FRAC_BITS];

  always_comb begin
    y_clip = !((&y_wide[cbq_pkg::YW_BITS-1:cbq_pkg::HIST_BITS-1]) ||
               (~|y_wide[cbq_pkg::YW_BITS-1:cbq_pkg::HIST_BITS-1]));
    if (y_clip) begin
      y_sat = y_wide[cbq_pkg::YW_BITS-1] ?
              {1'b1, {(cbq_pkg::HIST_BITS-1){1'b0}}} :
              {1'b0, {(cbq_pkg::HIST_BITS-1){1'b1}}};
    end else begin
      y_sat = y_wide[cbq_pkg::HIST_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      phase     <= cbq_pkg::SLOT_B0;
      out_valid <= 1'b0;
      x1        <= '0;
      x2        <= '0;
      y1        <= '0;
      y2        <= '0;
    end else begin
      out_valid <= (prev.valid && !busy && !ctrl.enable) ||
                   (busy && (phase == cbq_pkg::SLOT_LAST));
      if (ctrl.clear) begin
        x1 <= '0;
        x2 <= '0;
        y1 <= '0;
        y2 <= '0;
      end
      if (prev.valid && !busy) begin
        if (ctrl.enable) begin
          busy  <= 1'b1;
          phase <= cbq_pkg::SLOT_B0;
        end
      end
      if (busy) begin
        phase <= phase + 1'b1;
        if (phase == cbq_pkg::SLOT_LAST) begin
          busy      <= 1'b0;
          x2        <= x1;
          x1        <= x0;
          y2        <= y1;
          y1        <= y_sat;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.coef_we) begin
      coef[ctrl.slot] <= ctrl.coef_value;
    end
    if (prev.valid && !busy) begin
      x0        <= prev.value;
      clip_l    <= prev.clip;
      acc       <= cbq_pkg::STAGE_ROUND;
      // disabled section: pass the beat straight on
      out_value <= prev.value;
      out_clip  <= prev.clip;
    end
    if (busy) begin
      if (phase != cbq_pkg::SLOT_LAST) begin
        prod     <= cbq_pkg::PROD_BITS'(coef_sel) * cbq_pkg::PROD_BITS'(operand);
        prod_neg <= (phase == cbq_pkg::SLOT_A1) || (phase == cbq_pkg::SLOT_A2);
      end
      if (phase != cbq_pkg::SLOT_B0) begin
        acc <= acc_sum;
      end
      if (phase == cbq_pkg::SLOT_LAST) begin
        out_value <= y_sat;
        out_clip  <= clip_l | y_clip;
      end
    end
  end

  assign next = '{valid: out_valid, value: out_value, clip: out_clip};

endmodule

// ===== sv/cascaded_biquad_iir_filter.sv =====
// ----------------------------------------------------------------------------
// cascaded_biquad_iir_filter: cascade of direct-form-1 biquad sections
// Row of section cells, final Q1.30 gain with saturation, output register.
// ----------------------------------------------------------------------------
// A filter beat (func 0) walks down a row of 16 section cells. An active
// cell takes the beat and runs its five products through its own 32x32
// multiplier, one per cycle, then rounds and registers the result; an
// inactive cell passes the beat on through its output register. After the
// row, the gain product is registered and then moved into the output
// register once that register is free; a stage count above 16 acts as 16.
// The input is held off until the result has moved into the output
// register, and the next beat can be taken in the cycle after. Coefficient
// writes, history clears and ignored codes give no result and do not hold
// off the input. Coefficients and history live inside the cells; an
// unwritten coefficient reads as whatever the register holds.
module cascaded_biquad_iir_filter (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [cbq_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [cbq_pkg::CFG_BITS-1:0]       cfg_data,
  cbq_in_if.sink                             samples,
  cbq_out_if.source                          results
);

  logic [cbq_pkg::SC_BITS-1:0]   stage_count;
  logic [cbq_pkg::GAIN_BITS-1:0] output_gain;
  logic                          busy;
  logic                          accept;

  cbq_pkg::link_t link [cbq_pkg::MAX_STAGES+1];
  cbq_pkg::ctrl_t ctrl [cbq_pkg::MAX_STAGES];

  logic signed [cbq_pkg::PROD_BITS-1:0]   gprod;
  logic                                   g_valid;
  logic                                   g_clip;
  logic signed [cbq_pkg::PROD_BITS-1:0]   gsum;
  logic signed [cbq_pkg::GW_BITS-1:0]     gw;
  logic                                   gw_clip;
  logic signed [cbq_pkg::SAMPLE_BITS-1:0] g_sat;

  logic                                   out_valid;
  logic signed [cbq_pkg::SAMPLE_BITS-1:0] out_sample;
  logic                                   out_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_count <= '0;
      output_gain <= cbq_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        cbq_pkg::REG_STAGE_COUNT: stage_count <= cfg_data[cbq_pkg::SC_BITS-1:0];
        cbq_pkg::REG_OUTPUT_GAIN: output_gain <= cfg_data[cbq_pkg::GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign samples.ready = !busy && !rst;
  assign accept        = samples.valid && samples.ready;

  assign link[0] = '{valid: accept && (samples.func == cbq_pkg::FUNC_FILTER),
                     value: cbq_pkg::HIST_BITS'(samples.sample_in),
                     clip:  1'b0};

  for (genvar s = 0; s < cbq_pkg::MAX_STAGES; s++) begin : g_cell
    assign ctrl[s] = '{
      clear:      accept && (samples.func == cbq_pkg::FUNC_CLEAR),
      coef_we:    accept && (samples.func == cbq_pkg::FUNC_COEF) &&
                  (int'(samples.coef_index) >= cbq_pkg::COEF_SLOTS * s) &&
                  (int'(samples.coef_index) < cbq_pkg::COEF_SLOTS * (s + 1)),
      slot:       cbq_pkg::SLOT_BITS'(int'(samples.coef_index) -
                                      cbq_pkg::COEF_SLOTS * s),
      coef_value: samples.coef_value,
      enable:     int'(stage_count) > s
    };

    cbq_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctrl (ctrl[s]),
      .prev (link[s]),
      .next (link[s+1])
    );
  end

  // final gain: round half up, saturate to the sample width
  assign gsum    = gprod + cbq_pkg::GAIN_ROUND;
  assign gw      = gsum[cbq_pkg::PROD_BITS-1:cbq_pkg::GAIN_FRAC];
  assign gw_clip = !((&gw[cbq_pkg::GW_BITS-1:cbq_pkg::SAMPLE_BITS-1]) ||
                     (~|gw[cbq_pkg::GW_BITS-1:cbq_pkg::SAMPLE_BITS-1]));

  always_comb begin
    if (gw_clip) begin
      g_sat = gw[cbq_pkg::GW_BITS-1] ?
              {1'b1, {(cbq_pkg::SAMPLE_BITS-1){1'b0}}} :
              {1'b0, {(cbq_pkg::SAMPLE_BITS-1){1'b1}}};
    end else begin
      g_sat = gw[cbq_pkg::SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      g_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (link[0].valid) begin
        busy <= 1'b1;
      end
      if (link[cbq_pkg::MAX_STAGES].valid) begin
        g_valid <= 1'b1;
      end
      if (g_valid && (!out_valid || results.ready)) begin
        // hand over to the output register and free the row
        out_valid <= 1'b1;
        g_valid   <= 1'b0;
        busy      <= 1'b0;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (link[cbq_pkg::MAX_STAGES].valid) begin
      gprod  <= cbq_pkg::PROD_BITS'(link[cbq_pkg::MAX_STAGES].value) *
                cbq_pkg::PROD_BITS'(signed'({1'b0, output_gain}));
      g_clip <= link[cbq_pkg::MAX_STAGES].clip;
    end
    if (g_valid && (!out_valid || results.ready)) begin
      out_sample <= g_sat;
      out_sat    <= g_clip | gw_clip;
    end
  end

  assign results.valid      = out_valid;
  assign results.sample_out = out_sample;
  assign results.saturated  = out_sat;

`ifndef SYNTH
  a_busy_after_filter: assert property (@(posedge clk) disable iff (rst)
    link[0].valid |=> busy)
    else $error("row not marked busy after a filter beat");

  a_idle_row_empty: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (!link[cbq_pkg::MAX_STAGES].valid && !g_valid))
    else $error("data in flight while the row is idle");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    link[cbq_pkg::MAX_STAGES].valid |-> !g_valid)
    else $error("gain stage overrun");

  a_gain_moves: assert property (@(posedge clk) disable iff (rst)
    (g_valid && !out_valid) |=> (out_valid && !g_valid))
    else $error("gain result not moved into an empty output register");
`endif

endmodule
